### sv/pphc_pkg.sv
`default_nettype none

package pphc_pkg;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] MODE_FIRST = 3'd0;
    localparam logic [2:0] MODE_LAST  = 3'd1;
    localparam logic [2:0] MODE_FAR   = 3'd2;
    localparam logic [2:0] MODE_NEAR  = 3'd3;
    localparam logic [2:0] MODE_INDEX = 3'd4;

    localparam logic [2:0] REG_SPEED = 3'd0;
    localparam logic [2:0] REG_TURN  = 3'd1;
    localparam logic [2:0] REG_TOL   = 3'd2;
    localparam logic [2:0] REG_MODE  = 3'd3;
    localparam logic [2:0] REG_INDEX = 3'd4;

    localparam logic [15:0] SPEED_RST = 16'd640;
    localparam logic [14:0] TURN_RST  = 15'd11520;
    localparam logic [30:0] TOL_RST   = 31'd327680;
    localparam logic [2:0]  MODE_RST  = MODE_INDEX;
    localparam logic [5:0]  INDEX_RST = 6'd10;

    localparam logic signed [17:0] DEG180_Q7    = 18'sd23040;
    localparam logic signed [17:0] DEG360_Q7    = 18'sd46080;
    localparam logic signed [17:0] DEAD_ZONE_Q7 = 18'sd1280;

    localparam logic signed [26:0] DEG90_Q16  = 27'sd5898240;
    localparam logic signed [26:0] DEG180_Q16 = 27'sd11796480;

    localparam logic signed [43:0] CORDIC_GAIN_Q30 = 44'sd652032874;
    localparam int MAX_STEPS = 24;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               path_first;
        logic signed [15:0] robot_yaw;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic               goal_valid;
        logic               odom_valid;
    } pphc_in_t;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_z;
        logic signed [15:0] turn_rate;
        logic               goal_reached;
        logic               goal_changed;
    } pphc_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } pphc_point_t;

    typedef struct packed {
        logic               start;
        logic               rotate;
        logic signed [32:0] vec_dx;
        logic signed [32:0] vec_dy;
        logic signed [15:0] rot_ang;
    } pphc_cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] heading;
        logic signed [33:0] cos_q30;
        logic signed [33:0] sin_q30;
    } pphc_cordic_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GOAL,
        S_GWAIT,
        S_SCAN,
        S_TRD,
        S_TDAT,
        S_VEC,
        S_ERR,
        S_TURN,
        S_ROT,
        S_VEL,
        S_EMIT
    } pphc_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_PRE,
        CS_NORM,
        CS_ITER,
        CS_POST
    } pphc_cordic_state_t;

    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0:  r = 22'd2949120;
                5'd1:  r = 22'd1740967;
                5'd2:  r = 22'd919879;
                5'd3:  r = 22'd466945;
                5'd4:  r = 22'd234379;
                5'd5:  r = 22'd117304;
                5'd6:  r = 22'd58666;
                5'd7:  r = 22'd29335;
                5'd8:  r = 22'd14668;
                5'd9:  r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [17:0] norm_q7(input logic signed [17:0] a);
        logic signed [17:0] r;
        begin
            if (a > DEG180_Q7) r = a - DEG360_Q7;
            else if (a < -DEG180_Q7) r = a + DEG360_Q7;
            else r = a;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### sv/pphc_path_mem.sv
`default_nettype none

module pphc_path_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire pphc_pkg::pphc_point_t wdata,
    input  wire logic [AW-1:0]        raddr,
    output pphc_pkg::pphc_point_t     rdata
);
    import pphc_pkg::*;

    pphc_point_t mem [DEPTH];
    pphc_point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/pphc_sqdist.sv
`default_nettype none

module pphc_sqdist #(
    parameter int TW = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [TW-1:0]      in_tag,
    input  wire logic signed [31:0] a_x,
    input  wire logic signed [31:0] b_x,
    input  wire logic signed [31:0] a_y,
    input  wire logic signed [31:0] b_y,
    output logic                    out_valid,
    output logic [TW-1:0]           out_tag,
    output logic [64:0]             out_sum
);
    import pphc_pkg::*;

    logic               va_reg, vb_reg, vc_reg;
    logic [TW-1:0]      ta_reg, tb_reg, tc_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [64:0]        sqx_reg, sqy_reg, sum_reg;
    logic signed [65:0] px, py;

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg  <= in_tag;
        dx_reg  <= 33'(a_x) - 33'(b_x);
        dy_reg  <= 33'(a_y) - 33'(b_y);
        tb_reg  <= ta_reg;
        sqx_reg <= px[64:0];
        sqy_reg <= py[64:0];
        tc_reg  <= tb_reg;
        sum_reg <= sqx_reg + sqy_reg;
    end

    assign out_valid = vc_reg;
    assign out_tag   = tc_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

### sv/pphc_cordic.sv
`default_nettype none

module pphc_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pphc_pkg::pphc_cordic_req_t req,
    output pphc_pkg::pphc_cordic_rsp_t     rsp
);
    import pphc_pkg::*;

    localparam int NSTEP = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
    localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);

    pphc_cordic_state_t state_reg, state_next;
    logic signed [43:0] x_reg, y_reg;
    logic signed [26:0] z_reg;
    logic [4:0]         i_reg;
    logic               rot_reg, neg_reg, zero_reg;
    logic               done_reg;
    logic signed [15:0] heading_reg;
    logic signed [33:0] cos_reg, sin_reg;

    logic signed [43:0] ay, m, xs, ys;
    logic signed [26:0] at, zr, zc;
    logic               up, small8, small1;

    always_comb
    begin
        ay     = (y_reg < 0) ? -y_reg : y_reg;
        m      = (x_reg > ay) ? x_reg : ay;
        small8 = m < 44'sd4294967296;
        small1 = m < 44'sd1099511627776;
        xs     = x_reg >>> i_reg;
        ys     = y_reg >>> i_reg;
        at     = $signed({5'd0, atan_q16(i_reg)});
        up     = rot_reg ? (z_reg >= 0) : (y_reg < 0);
        if (z_reg >= 0) zr = (z_reg + 27'sd256) >>> 9;
        else zr = -((-z_reg + 27'sd256) >>> 9);
        if (zr > 27'(DEG180_Q7)) zc = 27'(DEG180_Q7);
        else if (zr < -27'(DEG180_Q7)) zc = -27'(DEG180_Q7);
        else zc = zr;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: if (req.start) state_next = CS_PRE;
            CS_PRE:
            begin
                if (rot_reg) state_next = CS_ITER;
                else if (x_reg == 0 && y_reg == 0) state_next = CS_POST;
                else state_next = CS_NORM;
            end
            CS_NORM: if (!small1) state_next = CS_ITER;
            CS_ITER: if (i_reg == LAST_STEP) state_next = CS_POST;
            CS_POST: state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == CS_POST);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CS_IDLE:
            begin
                if (req.start)
                begin
                    rot_reg <= req.rotate;
                    i_reg   <= 5'd0;
                    if (req.rotate)
                    begin
                        x_reg <= CORDIC_GAIN_Q30;
                        y_reg <= 44'sd0;
                        z_reg <= 27'(req.rot_ang) <<< 9;
                    end
                    else
                    begin
                        x_reg <= 44'(req.vec_dx);
                        y_reg <= 44'(req.vec_dy);
                        z_reg <= 27'sd0;
                    end
                end
            end
            CS_PRE:
            begin
                if (rot_reg)
                begin
                    if (z_reg > DEG90_Q16)
                    begin
                        z_reg   <= z_reg - DEG180_Q16;
                        neg_reg <= 1'b1;
                    end
                    else if (z_reg < -DEG90_Q16)
                    begin
                        z_reg   <= z_reg + DEG180_Q16;
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        neg_reg <= 1'b0;
                    end
                end
                else
                begin
                    zero_reg <= (x_reg == 0 && y_reg == 0);
                    if (x_reg < 0)
                    begin
                        z_reg <= (y_reg >= 0) ? DEG180_Q16 : -DEG180_Q16;
                        x_reg <= -x_reg;
                        y_reg <= -y_reg;
                    end
                    else
                    begin
                        z_reg <= 27'sd0;
                    end
                end
            end
            CS_NORM:
            begin
                if (small8)
                begin
                    x_reg <= x_reg <<< 8;
                    y_reg <= y_reg <<< 8;
                end
                else if (small1)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            CS_ITER:
            begin
                if (up)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 5'd1;
            end
            CS_POST:
            begin
                heading_reg <= zero_reg ? 16'sd0 : 16'(zc);
                cos_reg     <= neg_reg ? 34'(-x_reg) : 34'(x_reg);
                sin_reg     <= neg_reg ? 34'(-y_reg) : 34'(y_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done    = done_reg;
    assign rsp.heading = heading_reg;
    assign rsp.cos_q30 = cos_reg;
    assign rsp.sin_q30 = sin_reg;

endmodule

`default_nettype wire

### sv/path_point_heading_controller_core.sv
// Path point heading controller.
// Items arrive on the item channel (valid/ready) and results leave on the
// result channel (valid/ready); configuration is a plain write port that
// takes one register per cycle; the user must write it only while the block
// is idle, which the block itself does not enforce. A store item gives no
// result and leaves the block idle. A clear item, or a tick that lacks path,
// goal or odometry, goes straight to the emit state and gives a stop result.
// In farthest and nearest modes a full tick reads every stored point from the
// path memory, one point per cycle, through the squared-distance pipeline;
// the shared CORDIC unit runs once for the heading, once for sine and cosine.
// One item is worked on at a time; the next item is taken as soon as the
// result has moved to the output register, even while that result waits.
// A stalled receiver holds the result steady and blocks only the next result.
// Reset empties the path, clears the goal-reached flag and loads the
// register defaults; the path memory itself is not cleared.
`default_nettype none

module path_point_heading_controller_core #(
    parameter int PATH_DEPTH   = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire pphc_pkg::pphc_in_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output pphc_pkg::pphc_out_t      result,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [30:0]         cfg_data
);
    import pphc_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int IW = (CW > 6) ? CW : 6;

    pphc_state_t state_reg, state_next;

    logic [15:0] speed_reg;
    logic [14:0] maxturn_reg;
    logic [30:0] tol_reg;
    logic [2:0]  mode_reg;
    logic [5:0]  sidx_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          reached_reg, reached_next;
    logic          out_valid_reg, out_valid_next;
    logic          rd_pend_reg;
    logic [CW-1:0] scan_addr_reg;
    logic [AW-1:0] rd_tag_reg, best_idx_reg, tgt_reg;
    logic [64:0]   best_sum_reg;
    logic [61:0]   tol2_reg;

    logic signed [31:0] rx_reg, ry_reg, gx_reg, gy_reg;
    logic signed [15:0] yaw_reg, head_reg, turn_reg;
    logic signed [17:0] nyaw_reg, err_reg;
    logic               changed_reg;
    logic signed [50:0] prod_s_reg, prod_c_reg;
    pphc_out_t          res_reg, out_reg;

    logic          acc, store_ok, scan_issue, emit_ok, now, better, idx_ok, missing;
    logic [CW-1:0] base;
    logic [AW-1:0] last_idx, idx_tgt, sel_tgt;
    logic [IW-1:0] idx_w;

    logic               mem_we;
    logic [AW-1:0]      mem_raddr;
    pphc_point_t        mem_wdata, mem_rdata;

    logic               sq_in_valid, sq_out_valid;
    logic [AW-1:0]      sq_in_tag, sq_out_tag;
    logic signed [31:0] sq_ax, sq_bx, sq_ay, sq_by;
    logic [64:0]        sq_sum;

    pphc_cordic_req_t   creq;
    pphc_cordic_rsp_t   crsp;

    logic signed [17:0] mt, half_p, half_n, tr;
    logic signed [50:0] prod_s, prod_c;

    function automatic logic signed [15:0] vel_out(input logic signed [50:0] v,
                                                   input logic negate);
        logic signed [51:0] w, r;
        logic signed [15:0] o;
        begin
            w = 52'(v);
            if (w >= 0) r = (w + 52'sd536870912) >>> 30;
            else r = -((-w + 52'sd536870912) >>> 30);
            if (negate) r = -r;
            if (r > 52'sd32767) o = 16'sd32767;
            else if (r < -52'sd32768) o = -16'sd32768;
            else o = 16'(r);
            return o;
        end
    endfunction

    pphc_path_mem #(
        .DEPTH(PATH_DEPTH),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(AW'(base)),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    pphc_sqdist #(
        .TW(AW)
    ) u_sqdist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sq_in_valid),
        .in_tag   (sq_in_tag),
        .a_x      (sq_ax),
        .b_x      (sq_bx),
        .a_y      (sq_ay),
        .b_y      (sq_by),
        .out_valid(sq_out_valid),
        .out_tag  (sq_out_tag),
        .out_sum  (sq_sum)
    );

    pphc_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (creq),
        .rsp  (crsp)
    );

    always_comb
    begin
        acc        = item_valid && (state_reg == S_IDLE);
        base       = item.path_first ? '0 : count_reg;
        store_ok   = base < CW'(PATH_DEPTH);
        last_idx   = AW'(count_reg - CW'(1));
        idx_w      = IW'(sidx_reg);
        idx_ok     = idx_w < IW'(count_reg);
        idx_tgt    = idx_ok ? AW'(idx_w) : last_idx;
        emit_ok    = !out_valid_reg || result_ready;
        now        = sq_sum < {3'b000, tol2_reg};
        missing    = (count_reg == '0) || !item.goal_valid || !item.odom_valid;
        scan_issue = (state_reg == S_SCAN) && (scan_addr_reg < count_reg);
        if (sq_out_tag == '0) better = 1'b1;
        else if (mode_reg == MODE_FAR) better = sq_sum > best_sum_reg;
        else better = sq_sum < best_sum_reg;

        case (mode_reg)
            MODE_LAST:  sel_tgt = last_idx;
            MODE_INDEX: sel_tgt = idx_tgt;
            default:    sel_tgt = '0;
        endcase

        mem_we    = acc && (item.op == OP_STORE) && store_ok;
        mem_wdata = '{x: item.pos_x, y: item.pos_y};
        mem_raddr = (state_reg == S_SCAN) ? AW'(scan_addr_reg) : tgt_reg;

        if (state_reg == S_GOAL)
        begin
            sq_in_valid = 1'b1;
            sq_in_tag   = '0;
            sq_ax       = gx_reg;
            sq_ay       = gy_reg;
        end
        else
        begin
            sq_in_valid = rd_pend_reg;
            sq_in_tag   = rd_tag_reg;
            sq_ax       = mem_rdata.x;
            sq_ay       = mem_rdata.y;
        end
        sq_bx = rx_reg;
        sq_by = ry_reg;

        creq.start   = (state_reg == S_TDAT) || (state_reg == S_TURN);
        creq.rotate  = (state_reg == S_TURN);
        creq.vec_dx  = 33'(mem_rdata.x) - 33'(rx_reg);
        creq.vec_dy  = 33'(mem_rdata.y) - 33'(ry_reg);
        creq.rot_ang = head_reg;

        mt     = $signed({3'b000, maxturn_reg});
        half_p = (err_reg + 18'sd1) >>> 1;
        half_n = -((-err_reg + 18'sd1) >>> 1);
        if (err_reg > DEAD_ZONE_Q7) tr = (half_p > mt) ? mt : half_p;
        else if (err_reg < -DEAD_ZONE_Q7) tr = (half_n < -mt) ? -mt : half_n;
        else tr = 18'sd0;

        prod_s = $signed({1'b0, speed_reg}) * crsp.sin_q30;
        prod_c = $signed({1'b0, speed_reg}) * crsp.cos_q30;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        reached_next   = reached_reg;
        out_valid_next = out_valid_reg && !result_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (item.op)
                        OP_STORE: count_next = store_ok ? base + CW'(1) : base;
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_EMIT;
                        end
                        OP_TICK: state_next = missing ? S_EMIT : S_GOAL;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_GOAL: state_next = S_GWAIT;
            S_GWAIT:
            begin
                if (sq_out_valid)
                begin
                    reached_next = now;
                    if (now) state_next = S_EMIT;
                    else if (mode_reg == MODE_FAR || mode_reg == MODE_NEAR)
                        state_next = S_SCAN;
                    else state_next = S_TRD;
                end
            end
            S_SCAN: if (sq_out_valid && sq_out_tag == last_idx) state_next = S_TRD;
            S_TRD:  state_next = S_TDAT;
            S_TDAT: state_next = S_VEC;
            S_VEC:  if (crsp.done) state_next = S_ERR;
            S_ERR:  state_next = S_TURN;
            S_TURN: state_next = S_ROT;
            S_ROT:  if (crsp.done) state_next = S_VEL;
            S_VEL:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            reached_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            speed_reg     <= SPEED_RST;
            maxturn_reg   <= TURN_RST;
            tol_reg       <= TOL_RST;
            mode_reg      <= MODE_RST;
            sidx_reg      <= INDEX_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            reached_reg   <= reached_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= scan_issue;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SPEED: speed_reg   <= cfg_data[15:0];
                    REG_TURN:  maxturn_reg <= cfg_data[14:0];
                    REG_TOL:   tol_reg     <= cfg_data;
                    REG_MODE:  mode_reg    <= cfg_data[2:0];
                    REG_INDEX: sidx_reg    <= cfg_data[5:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    rx_reg  <= item.pos_x;
                    ry_reg  <= item.pos_y;
                    gx_reg  <= item.goal_x;
                    gy_reg  <= item.goal_y;
                    yaw_reg <= item.robot_yaw;
                    res_reg <= '{vel_x: 16'sd0, vel_z: 16'sd0, turn_rate: 16'sd0,
                                 goal_reached: reached_reg, goal_changed: 1'b0};
                end
            end
            S_GOAL:
            begin
                tol2_reg <= 62'(tol_reg) * 62'(tol_reg);
                nyaw_reg <= norm_q7(-(18'(yaw_reg)));
            end
            S_GWAIT:
            begin
                if (sq_out_valid)
                begin
                    changed_reg   <= now != reached_reg;
                    res_reg       <= '{vel_x: 16'sd0, vel_z: 16'sd0, turn_rate: 16'sd0,
                                      goal_reached: now, goal_changed: now != reached_reg};
                    tgt_reg       <= sel_tgt;
                    scan_addr_reg <= '0;
                end
            end
            S_SCAN:
            begin
                if (scan_issue) scan_addr_reg <= scan_addr_reg + CW'(1);
                rd_tag_reg <= AW'(scan_addr_reg);
                if (sq_out_valid && better)
                begin
                    best_sum_reg <= sq_sum;
                    best_idx_reg <= sq_out_tag;
                end
                if (sq_out_valid && sq_out_tag == last_idx)
                    tgt_reg <= better ? sq_out_tag : best_idx_reg;
            end
            S_VEC:  if (crsp.done) head_reg <= crsp.heading;
            S_ERR:  err_reg <= norm_q7(-(18'(head_reg)) - nyaw_reg);
            S_TURN: turn_reg <= 16'(tr);
            S_ROT:
            begin
                if (crsp.done)
                begin
                    prod_s_reg <= prod_s;
                    prod_c_reg <= prod_c;
                end
            end
            S_VEL:
            begin
                res_reg <= '{vel_x: vel_out(prod_s_reg, 1'b1),
                             vel_z: vel_out(prod_c_reg, 1'b0),
                             turn_rate: turn_reg,
                             goal_reached: reached_reg,
                             goal_changed: changed_reg};
            end
            S_EMIT: if (emit_ok) out_reg <= res_reg;
            default:
            begin
            end
        endcase
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

### sv/pphc_checker.sv
`default_nettype none

module pphc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire pphc_pkg::pphc_in_t  item,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire pphc_pkg::pphc_out_t result,
    input wire logic                cfg_we,
    input wire logic [2:0]          cfg_index,
    input wire logic [30:0]         cfg_data
);
    import pphc_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    a_reached_stops: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.goal_reached |->
            result.vel_x == 16'sd0 && result.vel_z == 16'sd0 &&
            result.turn_rate == 16'sd0)
        else $error("motion commanded with goal reached");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.turn_rate <= 16'sd11520 && result.turn_rate >= -16'sd11520)
        else $error("turn rate beyond half of a half turn");

endmodule

bind path_point_heading_controller_core pphc_checker u_pphc_checker (.*);

`default_nettype wire

### tb/sv/pphc_scoreboard.sv
`timescale 1ns / 100ps

module pphc_scoreboard
    import pphc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire logic      item_ready,
    input  wire pphc_in_t  item,
    input  wire logic      result_valid,
    input  wire logic      result_ready,
    input  wire pphc_out_t result,
    input  wire logic      cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [30:0] cfg_data,
    output int             errors,
    output int             pending
);

    localparam int STEPS = 16;
    localparam int DEPTH = 64;
    localparam longint ARCTAN [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic signed [31:0] pts_x [DEPTH];
    logic signed [31:0] pts_y [DEPTH];
    int                 n_pts;
    bit                 at_goal;
    logic [15:0]        speed;
    logic [14:0]        turn_max;
    logic [30:0]        tol;
    logic [2:0]         mode;
    logic [5:0]         sel_idx;
    pphc_out_t          expected_q [$];

    assign pending = expected_q.size();

    function automatic longint rnd_shift(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int wrap_deg(int a);
        while (a > 23040)
            a -= 46080;
        while (a < -23040)
            a += 46080;
        return a;
    endfunction

    function automatic logic [64:0] dist2(longint dx, longint dy);
        logic [63:0] ax;
        logic [63:0] ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        return {1'b0, ax * ax} + {1'b0, ay * ay};
    endfunction

    function automatic int bearing(longint dx, longint dy);
        longint base;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint m;
        longint ay;
        int k;
        base = 0;
        z = 0;
        k = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (dx < 0)
        begin
            base = (dy >= 0) ? 180 * 65536 : -180 * 65536;
            dx = -dx;
            dy = -dy;
        end
        ay = (dy < 0) ? -dy : dy;
        m = (ay > dx) ? ay : dx;
        while (m < (64'sd1 <<< 40))
        begin
            m = m <<< 1;
            k++;
        end
        x = dx <<< k;
        y = dy <<< k;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ARCTAN[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ARCTAN[i];
            end
            x = nx;
            y = ny;
        end
        z = rnd_shift(base + z, 9);
        if (z > 23040)
            z = 23040;
        if (z < -23040)
            z = -23040;
        return int'(z);
    endfunction

    function automatic void rotate(int a, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        longint ny;
        bit flip;
        z = longint'(a) * 512;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 90 * 65536)
        begin
            z -= 180 * 65536;
            flip = 1;
        end
        else if (z < -90 * 65536)
        begin
            z += 180 * 65536;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ARCTAN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ARCTAN[i];
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic int choose_target(longint rx, longint ry);
        int sel;
        logic [64:0] best;
        logic [64:0] d;
        sel = 0;
        best = '0;
        case (mode)
            MODE_LAST:
                return n_pts - 1;
            MODE_FAR, MODE_NEAR:
            begin
                for (int i = 0; i < n_pts; i++)
                begin
                    d = dist2(longint'(pts_x[i]) - rx, longint'(pts_y[i]) - ry);
                    if (i == 0 || (mode == MODE_FAR && d > best) ||
                        (mode == MODE_NEAR && d < best))
                    begin
                        best = d;
                        sel = i;
                    end
                end
                return sel;
            end
            MODE_INDEX:
                return (sel_idx < n_pts) ? int'(sel_idx) : n_pts - 1;
            default:
                return 0;
        endcase
    endfunction

    function automatic bit steer(pphc_in_t it, output pphc_out_t r);
        longint rx;
        longint ry;
        longint c;
        longint s;
        longint tr;
        logic [64:0] d;
        bit now;
        int t;
        int head;
        int err;
        r = '0;
        rx = it.pos_x;
        ry = it.pos_y;
        tr = 0;
        case (it.op)
            OP_STORE:
            begin
                if (it.path_first)
                    n_pts = 0;
                if (n_pts < DEPTH)
                begin
                    pts_x[n_pts] = it.pos_x;
                    pts_y[n_pts] = it.pos_y;
                    n_pts++;
                end
                return 0;
            end
            OP_CLEAR:
            begin
                n_pts = 0;
                r.goal_reached = at_goal;
                return 1;
            end
            OP_TICK:
            begin
                if (n_pts == 0 || !it.goal_valid || !it.odom_valid)
                begin
                    r.goal_reached = at_goal;
                    return 1;
                end
                d = dist2(longint'(it.goal_x) - rx, longint'(it.goal_y) - ry);
                now = d < {34'd0, tol} * {34'd0, tol};
                r.goal_changed = (now != at_goal);
                at_goal = now;
                r.goal_reached = at_goal;
                if (at_goal)
                    return 1;
                t = choose_target(rx, ry);
                head = bearing(longint'(pts_x[t]) - rx, longint'(pts_y[t]) - ry);
                err = wrap_deg(-head - wrap_deg(-int'(it.robot_yaw)));
                if (err > 1280 || err < -1280)
                begin
                    tr = (err > 0) ? (longint'(err) + 1) / 2 : -((longint'(-err) + 1) / 2);
                    if (tr > longint'(turn_max))
                        tr = turn_max;
                    if (tr < -longint'(turn_max))
                        tr = -longint'(turn_max);
                end
                rotate(head, c, s);
                r.vel_x = sat16(-rnd_shift(longint'(speed) * s, 30));
                r.vel_z = sat16(rnd_shift(longint'(speed) * c, 30));
                r.turn_rate = tr;
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    initial
        errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        pphc_out_t r;
        pphc_out_t e;
        if (!rst_n)
        begin
            n_pts = 0;
            at_goal = 0;
            speed = SPEED_RST;
            turn_max = TURN_RST;
            tol = TOL_RST;
            mode = MODE_RST;
            sel_idx = INDEX_RST;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SPEED: speed = cfg_data[15:0];
                    REG_TURN:  turn_max = cfg_data[14:0];
                    REG_TOL:   tol = cfg_data;
                    REG_MODE:  mode = cfg_data[2:0];
                    REG_INDEX: sel_idx = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                if (steer(item, r))
                    expected_q.push_back(r);
            end
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("[%0t] result transfer with nothing expected", $realtime);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (result.vel_x !== e.vel_x)
                        report_mismatch("vel_x", result.vel_x, e.vel_x);
                    if (result.vel_z !== e.vel_z)
                        report_mismatch("vel_z", result.vel_z, e.vel_z);
                    if (result.turn_rate !== e.turn_rate)
                        report_mismatch("turn_rate", result.turn_rate, e.turn_rate);
                    if (result.goal_reached !== e.goal_reached)
                        report_mismatch("goal_reached", result.goal_reached, e.goal_reached);
                    if (result.goal_changed !== e.goal_changed)
                        report_mismatch("goal_changed", result.goal_changed, e.goal_changed);
                end
            end
        end
    end

endmodule

### tb/sv/tb_path_point_heading_controller_core.sv
`timescale 1ns / 100ps

module tb_path_point_heading_controller_core;
    import pphc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 200;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    pphc_in_t    item;
    logic        result_valid;
    logic        result_ready;
    pphc_out_t   result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    int          idle_pct;
    int          stall_pct;
    bit          hold_go;
    bit          hold_done;
    int          hold_cnt;
    int          sent;

    path_point_heading_controller_core uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pphc_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
        clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            result_ready <= 0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_cnt <= 600;
            hold_done <= 1;
            result_ready <= 0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send(pphc_in_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1;
        do
            @(posedge clk);
        while (!item_ready);
        if (it.op != 2'd3)
            sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic drain;
        item_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [31:0] coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 2 ** 23)) - 2 ** 22;
        endcase
    endfunction

    function automatic pphc_in_t point(bit first);
        pphc_in_t it;
        it = '0;
        it.op = OP_STORE;
        it.pos_x = coord();
        it.pos_y = coord();
        it.path_first = first;
        it.robot_yaw = $urandom;
        it.goal_x = $urandom;
        it.goal_y = $urandom;
        it.goal_valid = $urandom;
        it.odom_valid = $urandom;
        return it;
    endfunction

    function automatic pphc_in_t tick();
        pphc_in_t it;
        it = '0;
        it.op = OP_TICK;
        it.pos_x = coord();
        it.pos_y = coord();
        it.path_first = $urandom;
        it.robot_yaw = $signed($urandom_range(0, 46080)) - 23040;
        if ($urandom_range(0, 2) == 0)
        begin
            it.goal_x = it.pos_x + $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
            it.goal_y = it.pos_y + $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
        end
        else
        begin
            it.goal_x = coord();
            it.goal_y = coord();
        end
        it.goal_valid = ($urandom_range(0, 9) != 0);
        it.odom_valid = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    task automatic random_traffic(int quota);
        pphc_in_t it;
        int len;
        int target;
        target = sent + quota;
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    it = tick();
                    it.op = $urandom_range(0, 1) ? OP_CLEAR : 2'd3;
                    send(it);
                end
                1:
                begin
                    it = tick();
                    it.pos_x = $urandom;
                    it.pos_y = $urandom;
                    it.goal_x = $urandom;
                    it.goal_y = $urandom;
                    it.robot_yaw = $signed($urandom_range(0, 46080)) - 23040;
                    send(it);
                end
                2:
                    send(point($urandom_range(0, 1)));
                default:
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(1, 8);
                    send(point(1));
                    for (int i = 1; i < len; i++)
                        send(point(0));
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        send(tick());
                end
            endcase
        end
    endtask

    task automatic directed;
        pphc_in_t it;
        it = tick();
        it.goal_valid = 1;
        it.odom_valid = 1;
        send(it);
        send(point(0));
        it.goal_valid = 0;
        send(it);
        it.goal_valid = 1;
        it.odom_valid = 0;
        send(it);
        it = point(1);
        it.pos_x = 32'sh7fffffff;
        it.pos_y = 32'sh80000000;
        send(it);
        it.path_first = 0;
        it.pos_x = 32'sh80000000;
        it.pos_y = 32'sh7fffffff;
        send(it);
        it = tick();
        it.goal_valid = 1;
        it.odom_valid = 1;
        it.goal_x = 32'sh7fffffff;
        it.goal_y = 32'sh7fffffff;
        it.pos_x = 32'sh80000000;
        it.pos_y = 32'sh80000000;
        it.robot_yaw = 16'sd23040;
        send(it);
        it.robot_yaw = -16'sd23040;
        it.pos_x = 32'sh7fffffff;
        it.pos_y = 32'sh7fffffff;
        send(it);
        it.goal_x = it.pos_x;
        it.goal_y = it.pos_y;
        send(it);
        send(it);
        it.goal_x = 0;
        send(it);
        it.op = 2'd3;
        send(it);
        it.op = OP_CLEAR;
        send(it);
        it.op = OP_TICK;
        send(it);
    endtask

    initial
    begin
        logic [30:0] vals [5];
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_ready = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_go = 0;
        hold_done = 0;
        hold_cnt = 0;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        directed();
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            vals[REG_SPEED] = (ph == 1) ? 0 : (ph == 2) ? 65535 : $urandom_range(0, 65535);
            vals[REG_TURN] = (ph == 3) ? 0 : (ph == 4) ? 23040 : $urandom_range(0, 23040);
            vals[REG_TOL] = (ph == 5) ? 0 : (ph == 6) ? 31'h7fffffff
                                          : $urandom_range(0, 2 ** 20);
            vals[REG_MODE] = ph % 8;
            vals[REG_INDEX] = (ph == 7) ? 63 : (ph == 8) ? 0 : $urandom_range(0, 63);
            for (int r = 0; r < 5; r++)
                write_reg(r, vals[r]);
            write_reg($urandom_range(5, 7), $urandom);
            if (ph == 9)
                hold_go <= 1;
            random_traffic(45);
            if (ph == 10)
            begin
                item_valid <= 0;
                while (pending != 0)
                    @(posedge clk);
            end
            random_traffic(45);
            drain();
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
sv/pphc_pkg.sv
sv/pphc_path_mem.sv
sv/pphc_sqdist.sv
sv/pphc_cordic.sv
sv/path_point_heading_controller_core.sv
sv/pphc_checker.sv
tb/sv/pphc_scoreboard.sv
tb/sv/tb_path_point_heading_controller_core.sv
